// ===== design/swssb_pkg.sv =====
// Shared types and constants for the strided window sum, scale and bias block.
package swssb_pkg;
    localparam int FRAME_MAX_DEF  = 64;
    localparam int WINDOW_MAX_DEF = 16;
    localparam int REG_IDX_W      = 2;
    localparam int REG_DATA_W     = 8;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE        = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_SIZE    = 2'd2;
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        T_ST_IDLE,
        T_ST_SUM,
        T_ST_MUL,
        T_ST_OUT
    } t_back_state;
endpackage

// ===== design/swssb_front.sv =====
// Front end: sample history writes, counters and job issue.
module swssb_front #(
    parameter int FRAME_MAX  = swssb_pkg::FRAME_MAX_DEF,
    parameter int WINDOW_MAX = swssb_pkg::WINDOW_MAX_DEF,
    parameter int FW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1,
    parameter int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_window_length,
    input  logic [7:0]  i_stride,
    input  logic [6:0]  i_frame_size,
    input  logic        i_accept,
    input  logic        i_action,
    input  logic [15:0] i_sample,
    input  logic        i_end_of_sequence,
    output logic        o_hist_we,
    output logic [SW+FW-1:0] o_hist_addr,
    output logic [15:0] o_hist_data,
    output logic        o_job_valid,
    output logic [FW-1:0] o_job_feature,
    output logic [SW-1:0] o_job_slot,
    output logic [8:0]  o_job_len,
    output logic [15:0] o_job_frame
);
    import swssb_pkg::*;

    logic [FW-1:0] r_feat;
    logic [15:0]   r_frame;
    logic [7:0]    r_phase;
    logic [15:0]   r_outcnt;
    logic [SW-1:0] r_slot;
    logic [8:0]    wl;
    logic [7:0]    st;
    logic [10:0]   fs;
    logic [FW-1:0] f;
    logic          win_ok, emit, last_feat, smp;

    always_comb begin
        wl = {4'd0, i_window_length};
        if (wl == 9'd0) wl = 9'd1;
        if (wl > 9'(WINDOW_MAX)) wl = 9'(WINDOW_MAX);
        st = (i_stride == 8'd0) ? 8'd1 : i_stride;
        fs = {4'd0, i_frame_size};
        if (fs == 11'd0) fs = 11'd1;
        if (fs > 11'(FRAME_MAX)) fs = 11'(FRAME_MAX);
        f = r_feat;
        smp = i_accept && (i_action == ACT_SAMPLE);
        win_ok = ({1'b0, r_frame} + 17'd1) >= {8'd0, wl};
        emit = win_ok && (r_phase == 8'd0);
        last_feat = ({{(11-FW){1'b0}}, r_feat} + 11'd1) >= fs;
    end

    assign o_hist_we     = smp;
    assign o_hist_addr   = {r_slot, f};
    assign o_hist_data   = i_sample;
    assign o_job_valid   = smp && emit;
    assign o_job_feature = f;
    assign o_job_slot    = r_slot;
    assign o_job_len     = wl;
    assign o_job_frame   = r_outcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat <= '0; r_frame <= '0; r_phase <= '0; r_outcnt <= '0; r_slot <= '0;
        end else if (smp) begin
            if (i_end_of_sequence) begin
                r_feat <= '0; r_frame <= '0; r_phase <= '0; r_outcnt <= '0; r_slot <= '0;
            end else if (last_feat) begin
                r_feat <= '0;
                if (emit) r_outcnt <= r_outcnt + 16'd1;
                if (win_ok) r_phase <= ((r_phase + 8'd1) >= st) ? 8'd0 : r_phase + 8'd1;
                if (r_frame != 16'hFFFF) r_frame <= r_frame + 16'd1;
                r_slot <= (32'(r_slot) + 1 >= WINDOW_MAX) ? '0 : r_slot + SW'(1);
            end else begin
                r_feat <= r_feat + FW'(1);
            end
        end
    end
endmodule

// ===== design/swssb_back.sv =====
// Back end: window sum over the history memory, scale, round, bias, saturate.
module swssb_back #(
    parameter int FRAME_MAX  = swssb_pkg::FRAME_MAX_DEF,
    parameter int WINDOW_MAX = swssb_pkg::WINDOW_MAX_DEF,
    parameter int FW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1,
    parameter int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hist_we,
    input  logic [SW+FW-1:0] i_hist_addr,
    input  logic [15:0] i_hist_data,
    input  logic        i_coef_we,
    input  logic [5:0]  i_coef_idx,
    input  logic [15:0] i_coef_weight,
    input  logic [31:0] i_coef_bias,
    input  logic        i_job_empty,
    output logic        o_job_pop,
    input  logic [FW-1:0] i_job_feature,
    input  logic [SW-1:0] i_job_slot,
    input  logic [8:0]  i_job_len,
    input  logic [15:0] i_job_frame,
    output logic        o_busy,
    output logic        o_res_valid,
    input  logic        i_res_pop,
    output logic [31:0] o_result,
    output logic [5:0]  o_out_feature,
    output logic [15:0] o_out_frame,
    output logic        o_saturated
);
    import swssb_pkg::*;

    logic [15:0] r_hist [WINDOW_MAX*FRAME_MAX];
    logic [15:0] r_wt [FRAME_MAX];
    logic [31:0] r_bs [FRAME_MAX];
    logic [15:0] r_rd;
    logic        r_rd_v;

    t_back_state r_state, n_state;
    logic [FW-1:0] r_f;
    logic [SW-1:0] r_s;
    logic [8:0]  r_left;
    logic [15:0] r_fr;
    logic signed [24:0] r_sum;
    logic signed [15:0] r_w;
    logic signed [31:0] r_b;
    logic signed [40:0] r_p;
    logic [31:0] r_res;
    logic [5:0]  r_of;
    logic [15:0] r_ofr;
    logic        r_sat;

    logic signed [41:0] p_r;
    logic signed [29:0] q;
    logic        rd_go, take;

    always_ff @(posedge i_clk) begin
        if (i_hist_we) r_hist[i_hist_addr] <= i_hist_data;
        if (i_coef_we && 32'(i_coef_idx) < FRAME_MAX) begin
            r_wt[i_coef_idx[FW-1:0]] <= i_coef_weight;
            r_bs[i_coef_idx[FW-1:0]] <= i_coef_bias;
        end
        r_rd <= r_hist[{r_s, r_f}];
    end

    assign take = (r_state == T_ST_IDLE) && !i_job_empty;
    assign o_job_pop = take;
    assign rd_go = (r_state == T_ST_SUM) && (r_left != 9'd0);
    // history and coefficients are still being read
    assign o_busy = r_state inside {T_ST_SUM, T_ST_MUL};

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_ST_IDLE: if (!i_job_empty) n_state = T_ST_SUM;
            T_ST_SUM:  if (r_left == 9'd0 && !r_rd_v) n_state = T_ST_MUL;
            T_ST_MUL:  n_state = T_ST_OUT;
            T_ST_OUT:  if (!o_res_valid || i_res_pop) n_state = T_ST_IDLE;
            default:   n_state = T_ST_IDLE;
        endcase
    end

    // round to nearest, ties up: floor((p + 2048) / 4096), then add bias
    always_comb begin
        p_r = {r_p[40], r_p} + 42'sd2048;
        q   = p_r[41:12];
    end

    logic signed [33:0] tot34;
    assign tot34 = 34'(signed'(q)) + 34'(r_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_ST_IDLE;
            r_rd_v <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v <= rd_go;
            if (r_state == T_ST_OUT && (!o_res_valid || i_res_pop)) o_res_valid <= 1'b1;
            else if (i_res_pop && o_res_valid) o_res_valid <= 1'b0;
        end
        if (take) begin
            r_f <= i_job_feature; r_s <= i_job_slot; r_left <= i_job_len;
            r_fr <= i_job_frame; r_sum <= '0;
        end
        if (rd_go) begin
            r_left <= r_left - 9'd1;
            r_s <= (r_s == '0) ? SW'(WINDOW_MAX - 1) : r_s - SW'(1);
        end
        if (r_rd_v) r_sum <= r_sum + 25'(signed'(r_rd));
        if (r_state == T_ST_SUM) begin
            r_w <= r_wt[r_f];
            r_b <= r_bs[r_f];
        end
        if (r_state == T_ST_MUL) r_p <= r_w * r_sum;
        if (r_state == T_ST_OUT && (!o_res_valid || i_res_pop)) begin
            r_of <= 6'(r_f); r_ofr <= r_fr;
            if (tot34 > 34'sh7FFFFFFF) begin
                r_res <= 32'h7FFFFFFF; r_sat <= 1'b1;
            end else if (tot34 < -34'sh80000000) begin
                r_res <= 32'h80000000; r_sat <= 1'b1;
            end else begin
                r_res <= tot34[31:0]; r_sat <= 1'b0;
            end
        end
    end

    assign o_result = r_res;
    assign o_out_feature = r_of;
    assign o_out_frame = r_ofr;
    assign o_saturated = r_sat;
endmodule

// ===== design/swssb_jobq.sv =====
// Short job queue between front and back ends.
module swssb_jobq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (32'(r_cnt) == DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full)
                r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + AW'(1);
            if (i_pop && !o_empty)
                r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

// ===== design/strided_window_sum_scale_bias.sv =====
// Top level of the strided window sum with per-feature scale and bias.
//  channel | handshake      | payload
//  input   | i_push / o_full| i_action .. i_end_of_sequence
//  result  | o_empty / i_pop| o_result, o_out_feature, o_out_frame, o_saturated
//  config  | i_cfg_we       | i_cfg_idx, i_cfg_data
// A load writes the back end coefficient tables directly; a non-emitting sample
// only writes the history and steps the front end counters. An emitting sample's
// window is summed in the back end through the single history read port feeding
// one accumulator, one sample a cycle. Input stalls while a job is queued or its
// sum and product are in progress, so no new transaction is taken until then.
// Reset is synchronous; a held result stalls the back end.
module strided_window_sum_scale_bias #(
    parameter int FRAME_MAX  = swssb_pkg::FRAME_MAX_DEF,
    parameter int WINDOW_MAX = swssb_pkg::WINDOW_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [swssb_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swssb_pkg::REG_DATA_W-1:0] i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_action,
    input  logic [5:0]  i_feature_index,
    input  logic [15:0] i_coeff_weight,
    input  logic [31:0] i_coeff_bias,
    input  logic [15:0] i_sample,
    input  logic        i_end_of_sequence,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_result,
    output logic [5:0]  o_out_feature,
    output logic [15:0] o_out_frame,
    output logic        o_saturated
);
    import swssb_pkg::*;
    localparam int FW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
    localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int JW = FW + SW + 9 + 16;

    logic [4:0] r_wl;
    logic [7:0] r_st;
    logic [6:0] r_fs;
    logic acc, hwe, jv, jfull, jempty, jpop, rv, bbusy;
    logic [SW+FW-1:0] haddr;
    logic [15:0] hdata, jfr, qfr;
    logic [FW-1:0] jf, qf;
    logic [SW-1:0] js, qs;
    logic [8:0] jl, ql;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= 5'd2; r_st <= 8'd1; r_fs <= 7'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_LENGTH: r_wl <= i_cfg_data[4:0];
                REG_STRIDE:        r_st <= i_cfg_data;
                REG_FRAME_SIZE:    r_fs <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // hold input until pending jobs are done with history and coefficients
    assign o_full = jfull || !jempty || bbusy;
    assign acc = i_push && !o_full;
    assign o_empty = !rv;

    swssb_front #(.FRAME_MAX(FRAME_MAX), .WINDOW_MAX(WINDOW_MAX)) u_front (
        .i_clk, .i_rst_n,
        .i_window_length(r_wl), .i_stride(r_st), .i_frame_size(r_fs),
        .i_accept(acc), .i_action, .i_sample, .i_end_of_sequence,
        .o_hist_we(hwe), .o_hist_addr(haddr), .o_hist_data(hdata),
        .o_job_valid(jv), .o_job_feature(jf), .o_job_slot(js),
        .o_job_len(jl), .o_job_frame(jfr)
    );

    swssb_jobq #(.WIDTH(JW), .DEPTH(4)) u_jobq (
        .i_clk, .i_rst_n,
        .i_push(jv), .i_data({jf, js, jl, jfr}), .o_full(jfull),
        .i_pop(jpop), .o_empty(jempty), .o_data({qf, qs, ql, qfr})
    );

    swssb_back #(.FRAME_MAX(FRAME_MAX), .WINDOW_MAX(WINDOW_MAX)) u_back (
        .i_clk, .i_rst_n,
        .i_hist_we(hwe), .i_hist_addr(haddr), .i_hist_data(hdata),
        .i_coef_we(acc && i_action == ACT_LOAD), .i_coef_idx(i_feature_index),
        .i_coef_weight(i_coeff_weight), .i_coef_bias(i_coeff_bias),
        .i_job_empty(jempty), .o_job_pop(jpop),
        .i_job_feature(qf), .i_job_slot(qs), .i_job_len(ql), .i_job_frame(qfr),
        .o_busy(bbusy),
        .o_res_valid(rv), .i_res_pop(i_pop),
        .o_result, .o_out_feature, .o_out_frame, .o_saturated
    );
endmodule

// ===== verif/strided_window_sum_scale_bias_test.sv =====
// Self-checking testbench for the strided window sum, scale and bias block.
`timescale 1ns / 1ps

module strided_window_sum_scale_bias_test;
    import swssb_pkg::*;

    localparam int RING_DEPTH    = 16;
    localparam int FEATURES      = 64;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_CYCLES  = 300;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int RANDOM_ITEMS  = 360;

    typedef struct {
        logic               action;
        logic [5:0]         fidx;
        logic signed [15:0] weight;
        logic signed [31:0] bias;
        logic signed [15:0] smp;
        logic               eos;
    } t_pool_item;

    typedef struct {
        logic [31:0] value;
        logic [5:0]  feat;
        logic [15:0] frame;
        logic        sat;
    } t_pool_res;

    typedef struct {
        t_pool_item item;
        bit         typed;
        t_pool_res  res;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [REG_IDX_W-1:0]  i_cfg_idx;
    logic [REG_DATA_W-1:0] i_cfg_data;
    logic        i_push;
    logic        o_full;
    logic        i_action;
    logic [5:0]  i_feature_index;
    logic [15:0] i_coeff_weight;
    logic [31:0] i_coeff_bias;
    logic [15:0] i_sample;
    logic        i_end_of_sequence;
    logic        o_empty;
    logic        i_pop;
    logic [31:0] o_result;
    logic [5:0]  o_out_feature;
    logic [15:0] o_out_frame;
    logic        o_saturated;

    strided_window_sum_scale_bias dut (.*);

    // predictor state
    logic signed [15:0] hist_ring [RING_DEPTH][FEATURES];
    logic signed [15:0] weight_tab [FEATURES];
    logic signed [31:0] bias_tab [FEATURES];
    int unsigned cfg_window, cfg_stride, cfg_frame;
    int unsigned feat_cnt, frame_cnt, phase_cnt, win_cnt, ring_pos;

    t_pool_res   pooled_q [$];
    int          errors;
    int          items_sent;
    int          results_seen;
    int          sat_seen;
    int          rx_idle_left;
    bit          rx_hold;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end
    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit predict_pool(input t_pool_item it, output t_pool_res r);
        int unsigned wl, st, fs, f, s;
        longint      sum, p, q, total;
        bit          emit;
        r = '{default: '0};
        if (it.action == ACT_LOAD) begin
            weight_tab[it.fidx] = it.weight;
            bias_tab[it.fidx]   = it.bias;
            return 1'b0;
        end
        wl = (cfg_window == 0) ? 1 : (cfg_window > RING_DEPTH) ? RING_DEPTH : cfg_window;
        st = (cfg_stride == 0) ? 1 : cfg_stride;
        fs = (cfg_frame == 0) ? 1 : (cfg_frame > FEATURES) ? FEATURES : cfg_frame;
        f  = (feat_cnt >= FEATURES) ? FEATURES - 1 : feat_cnt;
        hist_ring[ring_pos][f] = it.smp;
        emit = (frame_cnt + 1 >= wl) && (phase_cnt == 0);
        if (emit) begin
            sum = 0;
            s   = ring_pos;
            for (int k = 0; k < wl; k++) begin
                sum += longint'(hist_ring[s][f]);
                s = (s == 0) ? RING_DEPTH - 1 : s - 1;
            end
            p     = longint'(weight_tab[f]) * sum + 2048;
            q     = p >>> 12;
            total = q + longint'(bias_tab[f]);
            r.sat = 1'b0;
            if (total > 64'sd2147483647) begin
                total = 64'sd2147483647;
                r.sat = 1'b1;
            end
            if (total < -64'sd2147483648) begin
                total = -64'sd2147483648;
                r.sat = 1'b1;
            end
            r.value = total[31:0];
            r.feat  = f[5:0];
            r.frame = win_cnt[15:0];
        end
        if (feat_cnt + 1 >= fs) begin
            feat_cnt = 0;
            if (emit) win_cnt = (win_cnt + 1) & 16'hFFFF;
            if (frame_cnt + 1 >= wl) phase_cnt = (phase_cnt + 1 >= st) ? 0 : phase_cnt + 1;
            if (frame_cnt < 16'hFFFF) frame_cnt++;
            ring_pos = (ring_pos + 1 >= RING_DEPTH) ? 0 : ring_pos + 1;
        end else begin
            feat_cnt++;
        end
        if (it.eos) begin
            feat_cnt  = 0;
            frame_cnt = 0;
            phase_cnt = 0;
            win_cnt   = 0;
            ring_pos  = 0;
        end
        return emit;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[REG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_WINDOW_LENGTH: cfg_window = val & 32'h1F;
            REG_STRIDE:        cfg_stride = val & 32'hFF;
            REG_FRAME_SIZE:    cfg_frame  = val & 32'h7F;
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned wl, input int unsigned st, input int unsigned fs);
        write_reg(REG_WINDOW_LENGTH, wl);
        write_reg(REG_STRIDE, st);
        write_reg(REG_FRAME_SIZE, fs);
    endtask

    // hold push high through back-to-back transactions, drop it only for a gap
    task automatic send_item(input t_pool_item it, input int gap, input bit typed,
                             input t_pool_res typed_res);
        t_pool_res r;
        @(negedge i_clk);
        i_push            = 1'b1;
        i_action          = it.action;
        i_feature_index   = it.fidx;
        i_coeff_weight    = it.weight;
        i_coeff_bias      = it.bias;
        i_sample          = it.smp;
        i_end_of_sequence = it.eos;
        do @(posedge i_clk); while (o_full);
        items_sent++;
        if (predict_pool(it, r)) pooled_q.push_back(typed ? typed_res : r);
        if (gap > 0) begin
            @(negedge i_clk);
            i_push = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_push = 1'b0;
        while (pooled_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pool_item rand_item(input logic action, input logic eos);
        t_pool_item it;
        it.action = action;
        it.fidx   = 6'($urandom_range(0, 63));
        it.weight = 16'($urandom);
        it.bias   = 32'($urandom);
        it.smp    = 16'($urandom);
        it.eos    = eos;
        return it;
    endfunction

    function automatic t_dir_row mk_row(input logic action, input int w, input int b,
                                        input int smp, input logic eos, input bit typed,
                                        input int value, input int frame, input bit sat);
        t_dir_row d;
        d.item = '{action: action, fidx: 6'd0, weight: w[15:0], bias: b, smp: smp[15:0],
                   eos: eos};
        d.typed = typed;
        d.res   = '{value: value, feat: 6'd0, frame: frame[15:0], sat: sat};
        return d;
    endfunction

    // result side: random pops, one long hold on request
    initial begin
        i_pop = 1'b0;
        rx_idle_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                rx_hold = 1'b0;
                i_pop   = 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
            end
            if (rx_idle_left > 0) begin
                i_pop = 1'b0;
                rx_idle_left--;
            end else begin
                i_pop = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pool_res want;
        if (i_rst_n && i_pop && !o_empty) begin
            results_seen++;
            if (o_saturated) sat_seen++;
            rx_idle_left = pick_gap();
            if (pooled_q.size() == 0) begin
                report_mismatch("unexpected result", o_result, 0);
            end else begin
                want = pooled_q.pop_front();
                if (o_result !== want.value) report_mismatch("result", o_result, want.value);
                if (o_out_feature !== want.feat)
                    report_mismatch("out_feature", o_out_feature, want.feat);
                if (o_out_frame !== want.frame)
                    report_mismatch("out_frame", o_out_frame, want.frame);
                if (o_saturated !== want.sat)
                    report_mismatch("saturated", o_saturated, want.sat);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_MAX);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row    rows [$];
        t_pool_res   none;
        t_pool_item  it;
        int          phase, rand_sent, budget, fs_eff, wl_eff, st_eff, nframes, used;
        int unsigned wl, st, fs;
        bit          stop_seq;

        errors = 0;
        items_sent = 0;
        results_seen = 0;
        sat_seen = 0;
        quiet_cycles = 0;
        rx_hold = 1'b0;
        none = '{default: '0};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_push = 1'b0;
        i_action = ACT_LOAD;
        i_feature_index = '0;
        i_coeff_weight = '0;
        i_coeff_bias = '0;
        i_sample = '0;
        i_end_of_sequence = 1'b0;
        cfg_window = 2;
        cfg_stride = 1;
        cfg_frame = 1;
        feat_cnt = 0;
        frame_cnt = 0;
        phase_cnt = 0;
        win_cnt = 0;
        ring_pos = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: one feature, one-frame windows, unit gain and extremes
        set_config(1, 1, 1);
        rows.push_back(mk_row(ACT_LOAD,   4096, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, 5, 0, 1, 5, 0, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, -32768, 0, 1, -32768, 1, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, 32767, 1, 1, 32767, 2, 0));
        // end of sequence on a load is ignored
        rows.push_back(mk_row(ACT_LOAD,   32767, 32'h7FFFFFFF, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, 32767, 1, 1, 32'h7FFFFFFF, 0, 1));
        rows.push_back(mk_row(ACT_LOAD,   -32768, 32'h80000000, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, 32767, 1, 1, 32'h80000000, 0, 1));
        // half gain: ties round toward plus infinity
        rows.push_back(mk_row(ACT_LOAD,   2048, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, 1, 0, 1, 1, 0, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, -1, 0, 1, 0, 1, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, 3, 0, 1, 2, 2, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, -3, 1, 1, -1, 3, 0));
        rows.push_back(mk_row(ACT_LOAD,   0, -5, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, 1234, 1, 1, -5, 0, 0));
        rows.push_back(mk_row(ACT_LOAD,   32'h7FFF, -1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(ACT_SAMPLE, 0, 0, -32768, 1, 0, 0, 0, 0));
        rows[15].item.fidx = 6'd63;
        foreach (rows[i]) send_item(rows[i].item, pick_gap(), rows[i].typed, rows[i].res);
        wait_idle();

        // load every feature so no window ever reads an unloaded coefficient
        for (int f = 0; f < FEATURES; f++) begin
            it = rand_item(ACT_LOAD, 1'($urandom_range(0, 1)));
            it.fidx = 6'(f);
            send_item(it, pick_gap(), 0, none);
        end
        wait_idle();

        phase = 0;
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            case (phase)
                0: begin wl = 1;  st = 1;   fs = 4;   end
                1: begin wl = 16; st = 255; fs = 2;   end
                2: begin wl = 0;  st = 0;   fs = 0;   end
                3: begin wl = 31; st = 3;   fs = 127; end
                4: begin wl = 5;  st = 2;   fs = 3;   end
                5: begin wl = 2;  st = 1;   fs = 64;  end
                default: begin
                    wl = $urandom_range(0, 31);
                    st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(1, 4);
                    fs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(0, 8);
                end
            endcase
            set_config(wl, st, fs);
            wl_eff = (wl == 0) ? 1 : (wl > RING_DEPTH) ? RING_DEPTH : wl;
            st_eff = (st == 0) ? 1 : st;
            fs_eff = (fs == 0) ? 1 : (fs > FEATURES) ? FEATURES : fs;
            if (phase == 0) rx_hold = 1'b1;
            budget = 60;
            used = 0;
            while (used < budget) begin
                nframes = wl_eff + $urandom_range(0, 3 * (st_eff > 8 ? 8 : st_eff));
                if (nframes * fs_eff > 90) nframes = (90 / fs_eff > 0) ? 90 / fs_eff : 1;
                stop_seq = 1'b0;
                for (int fr = 0; fr < nframes && !stop_seq; fr++) begin
                    for (int ft = 0; ft < fs_eff && !stop_seq; ft++) begin
                        if ($urandom_range(0, 15) == 0) begin
                            send_item(rand_item(ACT_LOAD, 1'($urandom_range(0, 1))),
                                      phase == 0 ? 0 : pick_gap(), 0, none);
                            used++;
                        end
                        // broken sequence: end early, dropping a partial frame
                        stop_seq = ($urandom_range(0, 59) == 0) ||
                                   (fr == nframes - 1 && ft == fs_eff - 1);
                        send_item(rand_item(ACT_SAMPLE, stop_seq),
                                  phase == 0 ? 0 : pick_gap(), 0, none);
                        used++;
                    end
                end
            end
            rand_sent += used;
            wait_idle();
            phase++;
        end

        @(negedge i_clk);
        i_push = 1'b0;
        while (pooled_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d items in %0d random phases, %0d results (%0d saturated)",
                 items_sent, phase, results_seen, sat_seen);
        $display("window, stride and frame size swept including zero and beyond range");
        if (errors == 0 && pooled_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
